[rtl/core/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, codes and small letter and square functions for the
// Playfair cipher engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pcf_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [7:0] char_t;
  typedef logic [6:0] ascii_t;
  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  // Square position kept as row and column so no divide by five is needed
  typedef struct packed {
    coord_t row;
    coord_t col;
  } rc_t;

  typedef struct packed {
    logic    valid;
    letter_t idx;
  } fold_t;

  // Input transaction kinds
  localparam mode_t MODE_CLEAR  = 3'd0;
  localparam mode_t MODE_KEY    = 3'd1;
  localparam mode_t MODE_FINISH = 3'd2;
  localparam mode_t MODE_TEXT   = 3'd3;
  localparam mode_t MODE_END    = 3'd4;

  localparam char_t CHAR_LOWER_A = 8'h61;
  localparam char_t CHAR_LOWER_Z = 8'h7a;
  localparam char_t CHAR_UPPER_A = 8'h41;
  localparam char_t CHAR_UPPER_Z = 8'h5a;
  localparam char_t CHAR_CASE_GAP = 8'd32;

  localparam letter_t LETTER_I    = 5'd8;
  localparam letter_t LETTER_J    = 5'd9;
  localparam letter_t LETTER_X    = 5'd23;
  localparam letter_t LETTER_LAST = 5'd25;

  localparam int     SQUARE_CELLS = 25;
  localparam int     ALPHABET     = 26;
  localparam coord_t SIDE_LAST    = 3'd4;

  // Uppercase, drop non-letters, fold J into I
  function automatic fold_t fold_letter(char_t c);
    fold_t f;
    char_t u;
    u = c;
    if (u >= CHAR_LOWER_A && u <= CHAR_LOWER_Z) begin
      u = u - CHAR_CASE_GAP;
    end
    f.valid = (u >= CHAR_UPPER_A) && (u <= CHAR_UPPER_Z);
    f.idx   = letter_t'(u - CHAR_UPPER_A);
    if (f.idx == LETTER_J) begin
      f.idx = LETTER_I;
    end
    return f;
  endfunction

  // Move one place along a side of the square, wrapping; dir 1 moves back
  function automatic coord_t step5(coord_t v, logic dir);
    coord_t r;
    if (dir) begin
      r = (v == '0) ? SIDE_LAST : v - 3'd1;
    end else begin
      r = (v == SIDE_LAST) ? '0 : v + 3'd1;
    end
    return r;
  endfunction

  function automatic cell_t cell_index(rc_t p);
    return cell_t'({p.row, 2'b00}) + cell_t'(p.row) + cell_t'(p.col);
  endfunction

  // Output cell for one letter of a pair, given its own and its partner's place
  function automatic cell_t pair_cell(rc_t self_p, rc_t other_p, logic dir);
    rc_t o;
    o = self_p;
    if (self_p.row == other_p.row) begin
      o.col = step5(self_p.col, dir);
    end else if (self_p.col == other_p.col) begin
      o.row = step5(self_p.row, dir);
    end else begin
      o.col = other_p.col;
    end
    return cell_index(o);
  endfunction

  function automatic ascii_t to_ascii(letter_t l);
    return ascii_t'(CHAR_UPPER_A) + ascii_t'(l);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pcf_channels.sv]
// ----------------------------------------------------------------------------
// pcf_channels
// Valid/ready channel interfaces for input, result and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcf_in_if;
  import pcf_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  char_t char_in;
  modport source(output valid, output mode, output char_in, input ready);
  modport sink(input valid, input mode, input char_in, output ready);
endinterface

interface pcf_out_if;
  import pcf_pkg::*;
  logic   valid;
  logic   ready;
  ascii_t char_out;
  logic   pair_last;
  modport source(output valid, output char_out, output pair_last, input ready);
  modport sink(input valid, input char_out, input pair_last, output ready);
endinterface

interface pcf_cfg_if;
  logic valid;
  logic ready;
  logic direction;
  modport source(output valid, output direction, input ready);
  modport sink(input valid, input direction, output ready);
endinterface

`default_nettype wire

[rtl/core/pcf_ram.sv]
// ----------------------------------------------------------------------------
// pcf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module pcf_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/playfair_cipher_engine.sv]
// ----------------------------------------------------------------------------
// playfair_cipher_engine
// Playfair cipher on a 5x5 key square without J. Key characters build the
// square, text characters are paired and each pair comes out as two letters.
// Clear key, a key character, a text character that completes no pair and a
// dropped non-letter are each handled in the idle state. Key finish walks the
// 26 letters through the single placement unit, one letter a cycle. A
// transaction that completes a pair (a text character or text end) holds the
// input while the pair goes through the position RAM and the square RAM,
// each with one read port, so two position reads and two square reads
// follow one another, then the two letters are loaded into the output
// register one after the other. The second letter may still wait in the
// output register while the next transaction is accepted. The direction
// register is sampled when a pair is computed; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_cipher_engine (
  input  logic      clk,
  input  logic      rst_n,
  pcf_in_if.sink    in_if,
  pcf_out_if.source out_if,
  pcf_cfg_if.sink   cfg_if
);

  import pcf_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FILL  = 8'b0000_0010,
    ST_RDA   = 8'b0000_0100,
    ST_RDB   = 8'b0000_1000,
    ST_MAP1  = 8'b0001_0000,
    ST_MAP2  = 8'b0010_0000,
    ST_EMIT1 = 8'b0100_0000,
    ST_EMIT2 = 8'b1000_0000
  } state_t;

  state_t  state_r, state_nxt;
  logic    direction_r;
  logic [ALPHABET-1:0] letter_used_r, letter_used_nxt;
  cell_t   fill_count_r, fill_count_nxt;
  coord_t  fill_row_r, fill_row_nxt;
  coord_t  fill_col_r, fill_col_nxt;
  letter_t pending_letter_r, pending_letter_nxt;
  logic    pending_valid_r, pending_valid_nxt;
  letter_t fill_idx_r, fill_idx_nxt;
  letter_t let_a_r, let_a_nxt;
  letter_t let_b_r, let_b_nxt;
  rc_t     pos_a_r, pos_a_nxt;
  rc_t     pos_b_r, pos_b_nxt;
  letter_t first_out_r, first_out_nxt;
  logic    out_valid_r, out_valid_nxt;
  ascii_t  out_char_r, out_char_nxt;
  logic    out_last_r, out_last_nxt;

  logic    in_fire;
  logic    out_free;
  fold_t   in_fold;
  logic    place_req;
  letter_t place_idx;
  logic    place_ok;

  logic    pos_re;
  letter_t pos_raddr;
  logic [$bits(rc_t)-1:0] pos_rdata;
  rc_t     pos_rd;
  logic    key_re;
  cell_t   key_raddr;
  letter_t key_rdata;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_fold  = fold_letter(in_if.char_in);
  assign pos_rd   = rc_t'(pos_rdata);

  // Letter to square position, written when a letter is placed
  pcf_ram #(
    .Width($bits(rc_t)),
    .Depth(ALPHABET)
  ) u_pos_ram (
    .clk  (clk),
    .we   (place_ok),
    .waddr(place_idx),
    .wdata({fill_row_r, fill_col_r}),
    .re   (pos_re),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  // Square cell to letter, written at the fill pointer
  pcf_ram #(
    .Width($bits(letter_t)),
    .Depth(SQUARE_CELLS)
  ) u_square_ram (
    .clk  (clk),
    .we   (place_ok),
    .waddr(fill_count_r),
    .wdata(place_idx),
    .re   (key_re),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  // Sequencer and placement unit
  always_comb begin
    state_nxt          = state_r;
    letter_used_nxt    = letter_used_r;
    fill_count_nxt     = fill_count_r;
    fill_row_nxt       = fill_row_r;
    fill_col_nxt       = fill_col_r;
    pending_letter_nxt = pending_letter_r;
    pending_valid_nxt  = pending_valid_r;
    fill_idx_nxt       = fill_idx_r;
    let_a_nxt          = let_a_r;
    let_b_nxt          = let_b_r;
    pos_a_nxt          = pos_a_r;
    pos_b_nxt          = pos_b_r;
    first_out_nxt      = first_out_r;
    out_valid_nxt      = out_valid_r;
    out_char_nxt       = out_char_r;
    out_last_nxt       = out_last_r;
    place_req          = 1'b0;
    place_idx          = in_fold.idx;
    pos_re             = 1'b0;
    pos_raddr          = let_a_r;
    key_re             = 1'b0;
    key_raddr          = '0;

    // Drop the output transaction once taken
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_if.mode)
            MODE_CLEAR: begin
              letter_used_nxt    = '0;
              fill_count_nxt     = '0;
              fill_row_nxt       = '0;
              fill_col_nxt       = '0;
              pending_letter_nxt = '0;
              pending_valid_nxt  = 1'b0;
            end
            MODE_KEY: begin
              place_req = in_fold.valid;
            end
            MODE_FINISH: begin
              fill_idx_nxt = '0;
              state_nxt    = ST_FILL;
            end
            MODE_TEXT: begin
              if (in_fold.valid) begin
                if (!pending_valid_r) begin
                  pending_letter_nxt = in_fold.idx;
                  pending_valid_nxt  = 1'b1;
                end else begin
                  let_a_nxt = pending_letter_r;
                  state_nxt = ST_RDA;
                  // Doubled letter when encrypting: insert X, keep the letter
                  if (!direction_r && in_fold.idx == pending_letter_r) begin
                    let_b_nxt = LETTER_X;
                  end else begin
                    let_b_nxt         = in_fold.idx;
                    pending_valid_nxt = 1'b0;
                  end
                end
              end
            end
            MODE_END: begin
              if (pending_valid_r) begin
                let_a_nxt         = pending_letter_r;
                let_b_nxt         = LETTER_X;
                pending_valid_nxt = 1'b0;
                state_nxt         = ST_RDA;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        place_req    = 1'b1;
        place_idx    = fill_idx_r;
        fill_idx_nxt = fill_idx_r + 5'd1;
        if (fill_idx_r == LETTER_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDA: begin
        pos_re    = 1'b1;
        pos_raddr = let_a_r;
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        pos_re    = 1'b1;
        pos_raddr = let_b_r;
        pos_a_nxt = pos_rd;
        state_nxt = ST_MAP1;
      end
      ST_MAP1: begin
        pos_b_nxt = pos_rd;
        key_re    = 1'b1;
        key_raddr = pair_cell(pos_a_r, pos_rd, direction_r);
        state_nxt = ST_MAP2;
      end
      ST_MAP2: begin
        first_out_nxt = key_rdata;
        key_re        = 1'b1;
        key_raddr     = pair_cell(pos_b_r, pos_a_r, direction_r);
        state_nxt     = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = to_ascii(first_out_r);
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT2;
        end
      end
      ST_EMIT2: begin
        // Square read data still holds the second letter
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = to_ascii(key_rdata);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Append a new letter to the square while room is left
    place_ok = place_req && (place_idx != LETTER_J) && !letter_used_r[place_idx]
               && (fill_count_r < cell_t'(SQUARE_CELLS));
    if (place_ok) begin
      letter_used_nxt[place_idx] = 1'b1;
      fill_count_nxt             = fill_count_r + 5'd1;
      if (fill_col_r == SIDE_LAST) begin
        fill_col_nxt = '0;
        fill_row_nxt = fill_row_r + 3'd1;
      end else begin
        fill_col_nxt = fill_col_r + 3'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      direction_r      <= 1'b0;
      letter_used_r    <= '0;
      fill_count_r     <= '0;
      fill_row_r       <= '0;
      fill_col_r       <= '0;
      pending_letter_r <= '0;
      pending_valid_r  <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      letter_used_r    <= letter_used_nxt;
      fill_count_r     <= fill_count_nxt;
      fill_row_r       <= fill_row_nxt;
      fill_col_r       <= fill_col_nxt;
      pending_letter_r <= pending_letter_nxt;
      pending_valid_r  <= pending_valid_nxt;
      out_valid_r      <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        direction_r <= cfg_if.direction;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fill_idx_r  <= fill_idx_nxt;
    let_a_r     <= let_a_nxt;
    let_b_r     <= let_b_nxt;
    pos_a_r     <= pos_a_nxt;
    pos_b_r     <= pos_b_nxt;
    first_out_r <= first_out_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_if.ready      = (state_r == ST_IDLE);
  assign cfg_if.ready     = 1'b1;
  assign out_if.valid     = out_valid_r;
  assign out_if.char_out  = out_char_r;
  assign out_if.pair_last = out_last_r;

`ifndef SYNTHESIS
  // Every placed letter is marked used exactly once
  a_used_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(letter_used_r) == 32'(fill_count_r))
    else $error("letter_used population differs from fill count");

  // Fill row and column track the fill pointer
  a_fill_rc_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cell_index({fill_row_r, fill_col_r}) == fill_count_r
    && fill_count_r <= cell_t'(SQUARE_CELLS))
    else $error("fill row/column out of step with fill count");

  // The first letter of a pair is always followed by its second letter
  a_pair_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.ready && !out_last_r)
    |=> (state_r == ST_EMIT2 || (out_valid_r && out_last_r)))
    else $error("first letter of a pair left without its second");
`endif

endmodule

`default_nettype wire
